/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RIWL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RIWL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RIWL_ASSERT(label, prop, msg)
`define RIWL_NEVER(label, cond, msg)
`endif
`endif

/* hdl/riwl_pkg.sv */
// ----------------------------------------------------------------------------
// riwl_pkg
// Sizes, codes and shared types of the run interval weight lookup.
// ----------------------------------------------------------------------------
package riwl_pkg;

  localparam int NUM_TABLES    = 4;
  localparam int MAX_RUNS      = 256;
  localparam int MAX_INTERVALS = 1024;

  localparam int DW    = 32;
  localparam int TID_W = 2;

  // Index and count widths.
  localparam int RUN_IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int RUN_CW = $clog2(MAX_RUNS + 1);
  localparam int IV_IW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int IV_CW  = $clog2(MAX_INTERVALS + 1);
  localparam int RUN_DEPTH = NUM_TABLES * MAX_RUNS;
  localparam int IV_DEPTH  = NUM_TABLES * MAX_INTERVALS;
  localparam int RUN_AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int IV_AW  = (IV_DEPTH > 1) ? $clog2(IV_DEPTH) : 1;
  localparam int SRCH_W = (IV_CW > RUN_CW) ? IV_CW : RUN_CW;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_ROW    = 2'd1,
    OP_COMMIT = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_MISS        = 4'd1,
    ST_UNREG       = 4'd2,
    ST_BAD_RANGE   = 4'd3,
    ST_BAD_WEIGHT  = 4'd4,
    ST_RUN_ORDER   = 4'd5,
    ST_FULL        = 4'd6,
    ST_REGISTERED  = 4'd7,
    ST_NO_ROWS     = 4'd8,
    ST_NOT_LOADING = 4'd9,
    ST_LS_ORDER    = 4'd10
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RUN_SRCH,
    S_RUN_CHK,
    S_IV_SRCH,
    S_IV_CHK
  } state_t;

  typedef enum logic [2:0] {
    SR_HOLD,
    SR_RUN_INIT,
    SR_RUN_STEP,
    SR_IV_INIT,
    SR_IV_STEP
  } srch_t;

  typedef enum logic [1:0] {
    RES_EXEC,
    RES_MISS,
    RES_IV
  } res_t;

  typedef struct packed {
    logic  latch;
    logic  exec;
    srch_t srch;
    logic  res_load;
    res_t  res_sel;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic q_unreg;
    logic more;
    logic run_hit;
    logic out_free;
  } ctl_sts_t;

  typedef struct packed {
    logic [DW-1:0]    key;
    logic [IV_IW-1:0] off;
    logic [IV_CW-1:0] cnt;
  } run_ent_t;

  typedef struct packed {
    logic [DW-1:0] ls_first;
    logic [DW-1:0] ls_last;
    logic [DW-1:0] weight;
  } iv_ent_t;

endpackage

/* hdl/riwl_if.sv */
// ----------------------------------------------------------------------------
// riwl_in_if / riwl_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface riwl_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [riwl_pkg::TID_W-1:0] table_id;
  logic [riwl_pkg::DW-1:0]   run_number;
  logic [riwl_pkg::DW-1:0]   ls_first;
  logic [riwl_pkg::DW-1:0]   ls_end;
  logic [riwl_pkg::DW-1:0]   weight_bits;
  logic [riwl_pkg::DW-1:0]   lumi_block;

  modport source (output valid, opcode, table_id, run_number, ls_first, ls_end,
                  weight_bits, lumi_block, input ready);
  modport sink (input valid, opcode, table_id, run_number, ls_first, ls_end,
                weight_bits, lumi_block, output ready);
endinterface

interface riwl_out_if;
  logic                    valid;
  logic                    ready;
  logic [3:0]              status;
  logic [riwl_pkg::DW-1:0] weight_out;

  modport source (output valid, status, weight_out, input ready);
  modport sink (input valid, status, weight_out, output ready);
endinterface

/* hdl/riwl_datapath.sv */
// ----------------------------------------------------------------------------
// riwl_datapath
// Table memories, load bookkeeping, search registers and the result register.
// ----------------------------------------------------------------------------
module riwl_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  riwl_pkg::ctl_cmd_t         cmd,
  output riwl_pkg::ctl_sts_t         sts,
  input  logic [1:0]                 in_opcode,
  input  logic [riwl_pkg::TID_W-1:0] in_table_id,
  input  logic [riwl_pkg::DW-1:0]    in_run_number,
  input  logic [riwl_pkg::DW-1:0]    in_ls_first,
  input  logic [riwl_pkg::DW-1:0]    in_ls_end,
  input  logic [riwl_pkg::DW-1:0]    in_weight_bits,
  input  logic [riwl_pkg::DW-1:0]    in_lumi_block,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 out_status,
  output logic [riwl_pkg::DW-1:0]    out_weight_out
);

  // Latched request word.
  riwl_pkg::op_t              op_r;
  logic [riwl_pkg::TID_W-1:0] tid_r;
  logic [riwl_pkg::DW-1:0]    run_r, start_r, end_r, wgt_r, lumi_r;

  // Load bookkeeping.
  logic [riwl_pkg::NUM_TABLES-1:0] registered_r;
  logic [riwl_pkg::RUN_CW-1:0]     runs_r [riwl_pkg::NUM_TABLES];
  logic [riwl_pkg::IV_CW-1:0]      ivs_r  [riwl_pkg::NUM_TABLES];
  logic                            active_r, active_nxt;
  logic [riwl_pkg::TID_W-1:0]      ltab_r, ltab_nxt;
  logic                            failed_r, failed_nxt;
  logic [riwl_pkg::DW-1:0]         prev_run_r, prev_run_nxt;
  logic [riwl_pkg::DW-1:0]         prev_begin_r, prev_begin_nxt;
  logic [riwl_pkg::IV_IW-1:0]      cur_off_r;
  logic [riwl_pkg::IV_CW-1:0]      cur_cnt_r;

  logic                            clear_cnt, set_reg, row_ok;
  riwl_pkg::status_t               ex_status;

  logic [riwl_pkg::TID_W-1:0]      tsel;
  logic                            reg_sel;
  logic [riwl_pkg::RUN_CW-1:0]     nr;
  logic [riwl_pkg::IV_CW-1:0]      ni;
  logic                            first_row, newrun;
  logic [riwl_pkg::RUN_CW-1:0]     slot;

  // Memories.
  riwl_pkg::run_ent_t run_mem [riwl_pkg::RUN_DEPTH];
  riwl_pkg::iv_ent_t  iv_mem  [riwl_pkg::IV_DEPTH];
  riwl_pkg::run_ent_t run_rd_r, run_wd;
  riwl_pkg::iv_ent_t  iv_rd_r, iv_wd;
  logic [riwl_pkg::RUN_AW-1:0] run_wa, run_ra;
  logic [riwl_pkg::IV_AW-1:0]  iv_wa, iv_ra;

  // Search unit.
  logic [riwl_pkg::SRCH_W-1:0] lo_r, hi_r, mid_r, off_r;
  logic [riwl_pkg::SRCH_W-1:0] nlo, nhi, nmid, rd_i;
  logic [riwl_pkg::SRCH_W:0]   sum;
  logic [riwl_pkg::IV_CW-1:0]  lim, cnt_c;
  logic                        more, adv, iv_end, iv_hit, run_hit;

  logic                        out_valid_r;
  logic [3:0]                  out_status_r;
  logic [riwl_pkg::DW-1:0]     out_weight_r;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= riwl_pkg::op_t'(in_opcode);
      tid_r   <= in_table_id;
      run_r   <= in_run_number;
      start_r <= in_ls_first;
      end_r   <= in_ls_end;
      wgt_r   <= in_weight_bits;
      lumi_r  <= in_lumi_block;
    end
  end

  // Rows and commits act on the table named at begin.
  assign tsel = (op_r == riwl_pkg::OP_ROW || op_r == riwl_pkg::OP_COMMIT) ? ltab_r : tid_r;
  assign reg_sel = registered_r[tsel];
  assign nr = runs_r[tsel];
  assign ni = ivs_r[tsel];
  assign first_row = (ni == '0);
  assign newrun = first_row || (run_r != prev_run_r);
  assign slot = newrun ? nr : nr - 1'b1;

  always_comb begin
    active_nxt     = active_r;
    ltab_nxt       = ltab_r;
    failed_nxt     = failed_r;
    prev_run_nxt   = prev_run_r;
    prev_begin_nxt = prev_begin_r;
    clear_cnt      = 1'b0;
    set_reg        = 1'b0;
    row_ok         = 1'b0;
    ex_status      = riwl_pkg::ST_OK;
    unique case (op_r)
      riwl_pkg::OP_BEGIN: begin
        if (int'(tid_r) >= riwl_pkg::NUM_TABLES) begin
          ex_status = riwl_pkg::ST_UNREG;
        end else begin
          active_nxt     = 1'b1;
          ltab_nxt       = tid_r;
          prev_run_nxt   = '0;
          prev_begin_nxt = '0;
          if (reg_sel) begin
            failed_nxt = 1'b1;
            ex_status  = riwl_pkg::ST_REGISTERED;
          end else begin
            failed_nxt = 1'b0;
            clear_cnt  = 1'b1;
          end
        end
      end
      riwl_pkg::OP_ROW: begin
        if (!active_r || failed_r) begin
          ex_status = riwl_pkg::ST_NOT_LOADING;
        end else begin
          priority if (end_r < start_r) begin
            ex_status = riwl_pkg::ST_BAD_RANGE;
          end else if (wgt_r[30:23] == 8'hFF) begin
            ex_status = riwl_pkg::ST_BAD_WEIGHT;
          end else if (!first_row && run_r < prev_run_r) begin
            ex_status = riwl_pkg::ST_RUN_ORDER;
          end else if (!newrun && start_r < prev_begin_r) begin
            ex_status = riwl_pkg::ST_LS_ORDER;
          end else if (ni >= riwl_pkg::IV_CW'(riwl_pkg::MAX_INTERVALS) ||
                       (newrun && nr >= riwl_pkg::RUN_CW'(riwl_pkg::MAX_RUNS))) begin
            ex_status = riwl_pkg::ST_FULL;
          end else begin
            row_ok = 1'b1;
          end
          if (row_ok) begin
            prev_run_nxt   = run_r;
            prev_begin_nxt = start_r;
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
      riwl_pkg::OP_COMMIT: begin
        if (!active_r) begin
          ex_status = riwl_pkg::ST_NOT_LOADING;
        end else begin
          active_nxt = 1'b0;
          priority if (failed_r) begin
            ex_status = riwl_pkg::ST_NOT_LOADING;
          end else if (ni == '0) begin
            ex_status = riwl_pkg::ST_NO_ROWS;
          end else if (reg_sel) begin
            ex_status = riwl_pkg::ST_REGISTERED;
          end else begin
            set_reg = 1'b1;
          end
        end
      end
      riwl_pkg::OP_QUERY: begin
        ex_status = (int'(tid_r) < riwl_pkg::NUM_TABLES && reg_sel) ?
                    riwl_pkg::ST_OK : riwl_pkg::ST_UNREG;
      end
      default: ex_status = riwl_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      registered_r <= '0;
      active_r     <= 1'b0;
      ltab_r       <= '0;
      failed_r     <= 1'b0;
      prev_run_r   <= '0;
      prev_begin_r <= '0;
      for (int i = 0; i < riwl_pkg::NUM_TABLES; i++) begin
        runs_r[i] <= '0;
        ivs_r[i]  <= '0;
      end
    end else if (cmd.exec) begin
      active_r     <= active_nxt;
      ltab_r       <= ltab_nxt;
      failed_r     <= failed_nxt;
      prev_run_r   <= prev_run_nxt;
      prev_begin_r <= prev_begin_nxt;
      if (set_reg) begin
        registered_r[tsel] <= 1'b1;
      end
      if (clear_cnt) begin
        runs_r[tsel] <= '0;
        ivs_r[tsel]  <= '0;
      end
      if (row_ok) begin
        ivs_r[tsel] <= ni + 1'b1;
        if (newrun) begin
          runs_r[tsel] <= nr + 1'b1;
        end
      end
    end
  end

  // The open run's entry is rewritten on every accepted row with its grown count.
  assign run_wd.key = run_r;
  assign run_wd.off = newrun ? ni[riwl_pkg::IV_IW-1:0] : cur_off_r;
  assign run_wd.cnt = newrun ? riwl_pkg::IV_CW'(1) : cur_cnt_r + 1'b1;
  assign iv_wd.ls_first = start_r;
  assign iv_wd.ls_last  = end_r;
  assign iv_wd.weight   = wgt_r;
  assign run_wa = riwl_pkg::RUN_AW'(int'(ltab_r) * riwl_pkg::MAX_RUNS +
                                    int'(slot[riwl_pkg::RUN_IW-1:0]));
  assign iv_wa  = riwl_pkg::IV_AW'(int'(ltab_r) * riwl_pkg::MAX_INTERVALS +
                                   int'(ni[riwl_pkg::IV_IW-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.exec && row_ok) begin
      cur_off_r <= run_wd.off;
      cur_cnt_r <= run_wd.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && row_ok) begin
      run_mem[run_wa] <= run_wd;
      iv_mem[iv_wa]   <= iv_wd;
    end
    run_rd_r <= run_mem[run_ra];
    iv_rd_r  <= iv_mem[iv_ra];
  end

  // One halving step per cycle: the compare uses the word read at mid_r,
  // and the next midpoint goes straight to the read port.
  always_comb begin
    nlo   = lo_r;
    nhi   = hi_r;
    lim   = riwl_pkg::IV_CW'(riwl_pkg::MAX_INTERVALS) - riwl_pkg::IV_CW'(run_rd_r.off);
    cnt_c = (run_rd_r.cnt > lim) ? lim : run_rd_r.cnt;
    unique case (cmd.srch)
      riwl_pkg::SR_RUN_INIT: begin
        nlo = '0;
        nhi = riwl_pkg::SRCH_W'(nr);
      end
      riwl_pkg::SR_RUN_STEP: begin
        if (run_rd_r.key < run_r) begin
          nlo = mid_r + 1'b1;
        end else begin
          nhi = mid_r;
        end
      end
      riwl_pkg::SR_IV_INIT: begin
        nlo = riwl_pkg::SRCH_W'(run_rd_r.off);
        nhi = riwl_pkg::SRCH_W'(run_rd_r.off) + riwl_pkg::SRCH_W'(cnt_c);
      end
      riwl_pkg::SR_IV_STEP: begin
        if (lumi_r < iv_rd_r.ls_first) begin
          nhi = mid_r;
        end else begin
          nlo = mid_r + 1'b1;
        end
      end
      default: begin
        nlo = lo_r;
        nhi = hi_r;
      end
    endcase
  end

  assign adv    = (cmd.srch != riwl_pkg::SR_HOLD);
  assign iv_end = (cmd.srch == riwl_pkg::SR_IV_INIT || cmd.srch == riwl_pkg::SR_IV_STEP);
  assign more   = (nlo < nhi);
  assign sum    = {1'b0, nlo} + {1'b0, nhi};
  // When a search ends, the run search reads its final slot and the interval
  // search reads the last interval starting at or below the lumi block.
  assign nmid   = more ? sum[riwl_pkg::SRCH_W:1] : (iv_end ? nlo - 1'b1 : nlo);
  assign rd_i   = adv ? nmid : mid_r;
  assign run_ra = riwl_pkg::RUN_AW'(int'(tid_r) * riwl_pkg::MAX_RUNS +
                                    int'(rd_i[riwl_pkg::RUN_IW-1:0]));
  assign iv_ra  = riwl_pkg::IV_AW'(int'(tid_r) * riwl_pkg::MAX_INTERVALS +
                                   int'(rd_i[riwl_pkg::IV_IW-1:0]));

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r  <= nlo;
      hi_r  <= nhi;
      mid_r <= nmid;
    end
    if (cmd.srch == riwl_pkg::SR_IV_INIT) begin
      off_r <= riwl_pkg::SRCH_W'(run_rd_r.off);
    end
  end

  assign run_hit = (lo_r < riwl_pkg::SRCH_W'(nr)) && (run_rd_r.key == run_r);
  assign iv_hit  = (lo_r != off_r) && (lumi_r >= iv_rd_r.ls_first) &&
                   (lumi_r <= iv_rd_r.ls_last);

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        riwl_pkg::RES_EXEC: begin
          out_status_r <= ex_status;
          out_weight_r <= '0;
        end
        riwl_pkg::RES_MISS: begin
          out_status_r <= riwl_pkg::ST_MISS;
          out_weight_r <= '0;
        end
        riwl_pkg::RES_IV: begin
          out_status_r <= iv_hit ? riwl_pkg::ST_OK : riwl_pkg::ST_MISS;
          out_weight_r <= iv_hit ? iv_rd_r.weight : '0;
        end
        default: begin
          out_status_r <= riwl_pkg::ST_MISS;
          out_weight_r <= '0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_weight_out = out_weight_r;

  assign sts.op       = op_r;
  assign sts.q_unreg  = (ex_status != riwl_pkg::ST_OK);
  assign sts.more     = more;
  assign sts.run_hit  = run_hit;
  assign sts.out_free = out_free;

endmodule

/* hdl/riwl_ctrl.sv */
// ----------------------------------------------------------------------------
// riwl_ctrl
// Sequencer: accepts one word, runs its operation or a query's run search,
// then interval search on a run hit; hands the result to the output register.
// ----------------------------------------------------------------------------
module riwl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  riwl_pkg::ctl_sts_t  sts,
  output riwl_pkg::ctl_cmd_t  cmd
);

  riwl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= riwl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.latch    = 1'b0;
    cmd.exec     = 1'b0;
    cmd.srch     = riwl_pkg::SR_HOLD;
    cmd.res_load = 1'b0;
    cmd.res_sel  = riwl_pkg::RES_EXEC;
    unique case (state_r)
      riwl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = riwl_pkg::S_EXEC;
        end
      end
      riwl_pkg::S_EXEC: begin
        if (sts.op == riwl_pkg::OP_QUERY && !sts.q_unreg) begin
          cmd.srch  = riwl_pkg::SR_RUN_INIT;
          state_nxt = sts.more ? riwl_pkg::S_RUN_SRCH : riwl_pkg::S_RUN_CHK;
        end else if (sts.out_free) begin
          cmd.exec     = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = riwl_pkg::S_IDLE;
        end
      end
      riwl_pkg::S_RUN_SRCH: begin
        cmd.srch  = riwl_pkg::SR_RUN_STEP;
        state_nxt = sts.more ? riwl_pkg::S_RUN_SRCH : riwl_pkg::S_RUN_CHK;
      end
      riwl_pkg::S_RUN_CHK: begin
        if (sts.run_hit) begin
          cmd.srch  = riwl_pkg::SR_IV_INIT;
          state_nxt = sts.more ? riwl_pkg::S_IV_SRCH : riwl_pkg::S_IV_CHK;
        end else if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = riwl_pkg::RES_MISS;
          state_nxt    = riwl_pkg::S_IDLE;
        end
      end
      riwl_pkg::S_IV_SRCH: begin
        cmd.srch  = riwl_pkg::SR_IV_STEP;
        state_nxt = sts.more ? riwl_pkg::S_IV_SRCH : riwl_pkg::S_IV_CHK;
      end
      riwl_pkg::S_IV_CHK: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = riwl_pkg::RES_IV;
          state_nxt    = riwl_pkg::S_IDLE;
        end
      end
      default: state_nxt = riwl_pkg::S_IDLE;
    endcase
  end

endmodule

/* hdl/run_interval_weight_lookup.sv */
// Timing: a begin, row or commit word is latched on acceptance and executed
// in S_EXEC, which also loads the result register once it is free. A query
// steps through S_EXEC, S_RUN_SRCH, S_RUN_CHK and, on a run hit, S_IV_SRCH
// and S_IV_CHK, a binary search over the runs, then over the run's intervals.
// One word is in flight; a finished result waits while the next is accepted.
// Reset (synchronous, rst_n low) unregisters all tables and closes any load.
// ----------------------------------------------------------------------------
// run_interval_weight_lookup
// Two-level sorted interval table: loads per-run interval blocks and answers
// weight queries by binary search over runs, then over intervals.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module run_interval_weight_lookup (
  input logic       clk,
  input logic       rst_n,
  riwl_in_if.sink   in_ch,
  riwl_out_if.source out_ch
);

  riwl_pkg::ctl_cmd_t cmd;
  riwl_pkg::ctl_sts_t sts;

  riwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  riwl_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_ch.opcode),
    .in_table_id    (in_ch.table_id),
    .in_run_number  (in_ch.run_number),
    .in_ls_first    (in_ch.ls_first),
    .in_ls_end      (in_ch.ls_end),
    .in_weight_bits (in_ch.weight_bits),
    .in_lumi_block  (in_ch.lumi_block),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_weight_out (out_ch.weight_out)
  );

  `RIWL_ASSERT(a_one_in_flight, in_ch.valid && in_ch.ready |=> !in_ch.ready, "busy accept")
  `RIWL_NEVER(a_res_overrun, cmd.res_load && !sts.out_free, "result overwrite")
  `RIWL_NEVER(a_srch_when_idle, cmd.srch != riwl_pkg::SR_HOLD && in_ch.ready, "idle search")
  `RIWL_NEVER(a_weight_on_miss, out_ch.valid && out_ch.status != riwl_pkg::ST_OK && out_ch.weight_out != '0, "miss weight")

endmodule
